// ===== rtl/spoe_pkg.sv =====
package spoe_pkg;

   localparam int OBSERVABLES_DEF = 256;
   localparam int MAX_TERMS_DEF   = 4;
   localparam int QUBITS_DEF      = 1024;

   localparam int CMD_W   = 2;
   localparam int OBS_W   = 8;
   localparam int QUBIT_W = 10;
   localparam int PAULI_W = 2;
   localparam int ACC_W   = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_MEASURE = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   // basis code that names no Pauli
   localparam logic [PAULI_W-1:0] PAULI_INVALID = 2'd3;

   localparam logic signed [ACC_W-1:0] SUM_MAX = 32'sh7fff_ffff;
   localparam logic signed [ACC_W-1:0] SUM_MIN = 32'sh8000_0000;
   localparam logic [ACC_W-1:0]        CNT_MAX = 32'hffff_ffff;

   // one word moving down the cell chain; sum and cnt collect read data
   typedef struct packed {
      logic                 valid;
      cmd_type              cmd;
      logic [OBS_W-1:0]     obs;
      logic [QUBIT_W-1:0]   qubit;
      logic [PAULI_W-1:0]   pauli;
      logic                 neg;
      logic                 last;
      logic [ACC_W-1:0]     sum;
      logic [ACC_W-1:0]     cnt;
   } word_type;

endpackage

// ===== rtl/shadow_pauli_observable_estimator.sv =====
// channel   direction  handshake              word
// req_*     in         start && !busy         command, index, qubit, basis, sign, last
// rsp_*     out        rsp_valid, one cycle   read index, sum, count, never-measured
//
// A word is taken every cycle; busy stays low.
// Each word walks a chain of OBSERVABLES cells, each registering it in turn, and a
// read result appears on rsp_* once its word leaves the last cell.
// Reset (synchronous) clears every cell's term count, sums and counts.
// Results are strobed for one cycle and cannot be held off.
module shadow_pauli_observable_estimator #(
   parameter int OBSERVABLES = spoe_pkg::OBSERVABLES_DEF,
   parameter int MAX_TERMS   = spoe_pkg::MAX_TERMS_DEF,
   parameter int QUBITS      = spoe_pkg::QUBITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [spoe_pkg::CMD_W-1:0]          req_command,
   input  logic [spoe_pkg::OBS_W-1:0]          req_observable_index,
   input  logic [spoe_pkg::QUBIT_W-1:0]        req_qubit_index,
   input  logic [spoe_pkg::PAULI_W-1:0]        req_pauli_basis,
   input  logic                                req_outcome_negative,
   input  logic                                req_last_qubit,
   output logic                                rsp_valid,
   output logic [spoe_pkg::OBS_W-1:0]          rsp_read_index,
   output logic signed [spoe_pkg::ACC_W-1:0]   rsp_outcome_sum,
   output logic [spoe_pkg::ACC_W-1:0]          rsp_match_count,
   output logic                                rsp_never_measured
);
   import spoe_pkg::*;

   word_type chain [OBSERVABLES+1];
   word_type tail;

   assign busy = 1'b0;

   always_comb begin
      chain[0].valid = start && !busy;
      chain[0].cmd   = cmd_type'(req_command);
      chain[0].obs   = req_observable_index;
      chain[0].qubit = req_qubit_index;
      chain[0].pauli = req_pauli_basis;
      chain[0].neg   = req_outcome_negative;
      chain[0].last  = req_last_qubit;
      chain[0].sum   = '0;
      chain[0].cnt   = '0;
   end

   for (genvar k = 0; k < OBSERVABLES; k++) begin : g_cell
      spoe_cell #(
         .CELL_ID   (k),
         .MAX_TERMS (MAX_TERMS),
         .QUBITS    (QUBITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_word   (chain[k]),
         .down_word (chain[k+1])
      );
   end

   assign tail               = chain[OBSERVABLES];
   assign rsp_valid          = tail.valid && (tail.cmd == CMD_READ);
   assign rsp_read_index     = tail.obs;
   assign rsp_outcome_sum    = $signed(tail.sum);
   assign rsp_match_count    = tail.cnt;
   assign rsp_never_measured = (tail.cnt == '0);

endmodule

// ===== rtl/spoe_cell.sv =====
module spoe_cell #(
   parameter int CELL_ID   = 0,
   parameter int MAX_TERMS = spoe_pkg::MAX_TERMS_DEF,
   parameter int QUBITS    = spoe_pkg::QUBITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  spoe_pkg::word_type up_word,
   output spoe_pkg::word_type down_word
);
   import spoe_pkg::*;

   localparam int CW = $clog2(MAX_TERMS + 1);

   logic [QUBIT_W-1:0]      pos_ff   [MAX_TERMS];
   logic [PAULI_W-1:0]      pauli_ff [MAX_TERMS];
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic                    prod_ff, prod_in;
   logic                    ovr_ff, ovr_in;
   logic signed [ACC_W-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0]        cnt_ff, cnt_in;
   word_type                word_ff, word_in;

   logic          addressed;
   logic          pauli_ok;
   logic          load_ok;
   logic [CW-1:0] hits;

   assign addressed = (32'(up_word.obs) == 32'(CELL_ID));
   assign pauli_ok  = (up_word.pauli != PAULI_INVALID);
   assign load_ok   = up_word.valid && (up_word.cmd == CMD_LOAD) && addressed && pauli_ok
                      && (32'(up_word.qubit) < 32'(QUBITS))
                      && (32'(count_ff) < 32'(MAX_TERMS));

   always_comb begin
      hits = '0;
      for (int t = 0; t < MAX_TERMS; t++) begin
         if ((32'(t) < 32'(count_ff)) && (pos_ff[t] == up_word.qubit)
             && (pauli_ff[t] == up_word.pauli)) begin
            hits = hits + CW'(1);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      ovr_in   = ovr_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      word_in  = up_word;
      if (up_word.valid) begin
         case (up_word.cmd)
            CMD_LOAD: begin
               if (load_ok) begin
                  count_in = count_ff + CW'(1);
                  rem_in   = count_ff + CW'(1);
                  prod_in  = 1'b0;
                  ovr_in   = 1'b0;
               end
            end
            CMD_MEASURE: begin
               if (pauli_ok && (hits != '0)) begin
                  if (hits > rem_ff) begin
                     ovr_in = 1'b1;
                     rem_in = '0;
                  end else begin
                     rem_in = rem_ff - hits;
                  end
                  if (up_word.neg && hits[0]) begin
                     prod_in = ~prod_ff;
                  end
               end
               // close the snapshot: credit a full match, then rearm
               if (up_word.last) begin
                  if ((rem_in == '0) && !ovr_in) begin
                     if (prod_in) begin
                        if (sum_ff != SUM_MIN) sum_in = sum_ff - 32'sd1;
                     end else begin
                        if (sum_ff != SUM_MAX) sum_in = sum_ff + 32'sd1;
                     end
                     if (cnt_ff != CNT_MAX) cnt_in = cnt_ff + 32'd1;
                  end
                  rem_in  = count_ff;
                  prod_in = 1'b0;
                  ovr_in  = 1'b0;
               end
            end
            CMD_READ: begin
               if (addressed) begin
                  word_in.sum = sum_ff;
                  word_in.cnt = cnt_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rem_ff        <= '0;
         prod_ff       <= 1'b0;
         ovr_ff        <= 1'b0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         word_ff.valid <= 1'b0;
      end else begin
         count_ff <= count_in;
         rem_ff   <= rem_in;
         prod_ff  <= prod_in;
         ovr_ff   <= ovr_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         word_ff.valid <= word_in.valid;
      end
      word_ff.cmd   <= word_in.cmd;
      word_ff.obs   <= word_in.obs;
      word_ff.qubit <= word_in.qubit;
      word_ff.pauli <= word_in.pauli;
      word_ff.neg   <= word_in.neg;
      word_ff.last  <= word_in.last;
      word_ff.sum   <= word_in.sum;
      word_ff.cnt   <= word_in.cnt;
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < MAX_TERMS; t++) begin
         if (load_ok && (32'(count_ff) == 32'(t))) begin
            pos_ff[t]   <= up_word.qubit;
            pauli_ff[t] <= up_word.pauli;
         end
      end
   end

   assign down_word = word_ff;

   a_rem_le_count: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= count_ff)
      else $error("remaining matches exceed term count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_TERMS))
      else $error("term count beyond capacity");

   a_ovr_rem_zero: assert property (@(posedge clock) disable iff (reset)
      ovr_ff |-> (rem_ff == '0))
      else $error("overrun with matches still pending");

   a_cnt_sum: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (sum_ff == '0))
      else $error("sum moved without a counted snapshot");

endmodule
